@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the stencil sweep RTL. They expect a clock
// named aclk and an active-low synchronous reset named aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset
`define JSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition must never be seen on a clock edge outside reset
`define JSS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ rtl/jss_pkg.sv @@
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and constants for the Jacobi / red-black SOR stencil sweep:
// register map, configuration bundle and per-point control flags.
// ----------------------------------------------------------------------------
`default_nettype none

package jss_pkg;

    // Default build sizes
    localparam int MAX_COLS_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int ROWS_W    = 13;
    localparam int COLS_W    = 11;
    localparam int WEIGHT_W  = 17;
    localparam int RES_W     = 56;
    localparam int IO_VAL_W  = 32;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam int ROW_LIMIT = 4096;

    // Register reset values
    localparam logic [ROWS_W-1:0]   ROWS_RST   = ROWS_W'(512);
    localparam logic [COLS_W-1:0]   COLS_RST   = COLS_W'(512);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(65536);

    // Sweep mode codes
    localparam logic MODE_JACOBI = 1'b0;
    localparam logic MODE_SOR    = 1'b1;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_ROWS   = 3'd0,
        REG_COLS   = 3'd1,
        REG_MODE   = 3'd2,
        REG_WEIGHT = 3'd3,
        REG_COLOUR = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [ROWS_W-1:0]   interior_rows;
        logic [COLS_W-1:0]   interior_cols;
        logic                sweep_mode;
        logic [WEIGHT_W-1:0] relax_weight;
        logic                colour_select;
    } cfg_t;

    // Control flags travelling with each point through the pipeline
    typedef struct packed {
        logic emit;       // interior point, produces a result
        logic last;       // final interior point of the sweep
        logic frame_end;  // last padded point, clears the residual
        logic sor;        // weighted SOR mode
        logic upd;        // point is of the selected colour
    } item_flags_t;

endpackage

`default_nettype wire

@@ rtl/jacobi_sor_stencil_sweep.sv @@
// ----------------------------------------------------------------------------
// jacobi_sor_stencil_sweep
// One sweep of a five-point stencil over a padded grid streamed in raster
// order: Jacobi average on every interior point, or weighted SOR on one
// colour, with a saturating running L1 residual.
//
//   Channel   Dir   Handshake                 Payload
//   s_        in    s_tvalid / s_tready       s_tdata: grid_value
//   m_        out   m_tvalid / m_tready       m_tdata: new_value, residual_sum
//                                             m_tlast: sweep_last
//   apb       in    psel / penable / pready   5 registers, byte address 4*i
//
// One grid point per clock while the output is not stalled; the line memory
// has one read and one write port and each point uses one of each.
// A result's m_tvalid is registered after its point below passes stages 1 to 4.
// Border points produce no result; the last padded point clears the residual.
// Reset clears counters, valids and the residual; the line memory needs no
// clearing pass, its entries are written before they are used.
// A stalled output backs up stage by stage; free stages keep taking input.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_sor_stencil_sweep
    import jss_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,   // [31:0] grid_value
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [87:0]              m_tdata,   // [31:0] new_value, [87:32] residual_sum
    output logic                     m_tlast,   // sweep_last
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    cfg_t                          cfg;
    logic                          win_valid, win_ready;
    item_flags_t                   win_flags;
    logic signed [VALUE_WIDTH-1:0] cur_val, up_val, left_val, mid_val, right_val;
    logic [IO_VAL_W-1:0]           new_value;
    logic [RES_W-1:0]              residual_sum;

    jss_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jss_window #(
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win_flags (win_flags),
        .cur_val   (cur_val),
        .up_val    (up_val),
        .left_val  (left_val),
        .mid_val   (mid_val),
        .right_val (right_val)
    );

    jss_relax #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_relax (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .relax_weight (cfg.relax_weight),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win_flags    (win_flags),
        .cur_val      (cur_val),
        .up_val       (up_val),
        .left_val     (left_val),
        .mid_val      (mid_val),
        .right_val    (right_val),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_new_value  (new_value),
        .m_residual   (residual_sum),
        .m_tlast      (m_tlast)
    );

    assign m_tdata = {residual_sum, new_value};

endmodule

`default_nettype wire

@@ rtl/jss_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// jss_cfg_regs
// APB-style register bank: grid size, sweep mode, relaxation weight and
// colour. Zero wait states; reads return the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_cfg_regs
    import jss_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interior_rows <= ROWS_RST;
            cfg_reg.interior_cols <= COLS_RST;
            cfg_reg.sweep_mode    <= MODE_JACOBI;
            cfg_reg.relax_weight  <= WEIGHT_RST;
            cfg_reg.colour_select <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_ROWS:   cfg_reg.interior_rows <= pwdata[ROWS_W-1:0];
                REG_COLS:   cfg_reg.interior_cols <= pwdata[COLS_W-1:0];
                REG_MODE:   cfg_reg.sweep_mode    <= pwdata[0];
                REG_WEIGHT: cfg_reg.relax_weight  <= pwdata[WEIGHT_W-1:0];
                REG_COLOUR: cfg_reg.colour_select <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (idx)
            REG_ROWS:   prdata = PDATA_W'(cfg_reg.interior_rows);
            REG_COLS:   prdata = PDATA_W'(cfg_reg.interior_cols);
            REG_MODE:   prdata = PDATA_W'(cfg_reg.sweep_mode);
            REG_WEIGHT: prdata = PDATA_W'(cfg_reg.relax_weight);
            REG_COLOUR: prdata = PDATA_W'(cfg_reg.colour_select);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/jss_window.sv @@
// ----------------------------------------------------------------------------
// jss_window
// Raster position counters, the line memory and the stencil window. Each
// memory entry holds one column of the last two rows {newer, older}. The
// entry one column ahead is read on acceptance; the entry of the current
// column is written back with {current, newer} when the point moves on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jss_window
    import jss_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cfg_t                          cfg,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [IO_VAL_W-1:0]           s_tdata,
    // window towards the update pipeline
    output logic                               win_valid,
    input  wire logic                          win_ready,
    output item_flags_t                        win_flags,
    output logic signed [VALUE_WIDTH-1:0]      cur_val,
    output logic signed [VALUE_WIDTH-1:0]      up_val,
    output logic signed [VALUE_WIDTH-1:0]      left_val,
    output logic signed [VALUE_WIDTH-1:0]      mid_val,
    output logic signed [VALUE_WIDTH-1:0]      right_val
);

    localparam int VW       = VALUE_WIDTH;
    localparam int LINE_LEN = MAX_COLS + 2;
    localparam int AW       = $clog2(LINE_LEN);
    localparam int MW       = 2 * VW;
    localparam int CW       = ((AW > COLS_W) ? AW : COLS_W) + 1;

    // Line memory
    logic [MW-1:0] line_mem [LINE_LEN];

    logic [ROWS_W-1:0] row_reg, row_next;
    logic [AW-1:0]     col_reg, col_next;

    logic              v1_reg;
    item_flags_t       flags1_reg, flags_next;
    logic [AW-1:0]     col1_reg;
    logic [VW-1:0]     cur1_reg;
    logic [MW-1:0]     rd_reg;
    logic [MW-1:0]     prev_reg;
    logic [VW-1:0]     left_reg;

    logic [CW-1:0]     cols_raw;
    logic [AW-1:0]     cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic              row_end, frame_end;
    logic [AW:0]       rd_addr;
    logic              rd_ok, wr_en, wr_ok, accept;

    // Effective grid size
    assign cols_raw = CW'(cfg.interior_cols);
    always_comb begin
        priority if (cols_raw == '0)
            cols_eff = AW'(1);
        else if (cols_raw > CW'(MAX_COLS))
            cols_eff = AW'(MAX_COLS);
        else
            cols_eff = AW'(cols_raw);

        priority if (cfg.interior_rows == '0)
            rows_eff = ROWS_W'(1);
        else if (cfg.interior_rows > ROWS_W'(ROW_LIMIT))
            rows_eff = ROWS_W'(ROW_LIMIT);
        else
            rows_eff = cfg.interior_rows;
    end

    // Position, flags and next read address
    assign row_end   = ({1'b0, col_reg} >= ({1'b0, cols_eff} + (AW+1)'(1)));
    assign frame_end = row_end && (row_reg >= rows_eff + ROWS_W'(1));

    always_comb begin
        flags_next.emit      = (row_reg >= ROWS_W'(2)) && (row_reg <= rows_eff + ROWS_W'(1))
                             && (col_reg >= AW'(1)) && (col_reg <= cols_eff);
        flags_next.last      = (row_reg == rows_eff + ROWS_W'(1)) && (col_reg == cols_eff);
        flags_next.frame_end = frame_end;
        flags_next.sor       = (cfg.sweep_mode == MODE_SOR);
        flags_next.upd       = (~(row_reg[0] ^ col_reg[0])) == cfg.colour_select;

        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + ROWS_W'(1);
        end else begin
            col_next = col_reg + AW'(1);
            row_next = row_reg;
        end
    end

    // At a row end, fetch column 0 so the next row starts with its window
    assign rd_addr  = row_end ? '0 : {1'b0, col_reg} + (AW+1)'(1);
    assign rd_ok    = (rd_addr < (AW+1)'(LINE_LEN));

    assign s_tready = !v1_reg || win_ready;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = v1_reg && win_ready;
    assign wr_ok    = ({1'b0, col1_reg} < (AW+1)'(LINE_LEN));

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            if (accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (s_tready)
                v1_reg <= s_tvalid;
        end
    end

    // Stage-1 payload and window shift
    always_ff @(posedge aclk) begin
        if (accept) begin
            flags1_reg <= flags_next;
            col1_reg   <= col_reg;
            cur1_reg   <= VW'(s_tdata);
            prev_reg   <= rd_reg;
            left_reg   <= rd_reg[MW-1:VW] == rd_reg[MW-1:VW] ? prev_reg[MW-1:VW]
                                                             : prev_reg[MW-1:VW];
        end
    end

    // Line memory: one read port, one write port
    always_ff @(posedge aclk) begin
        if (accept && rd_ok)
            rd_reg <= line_mem[rd_addr[AW-1:0]];
        if (wr_en && wr_ok)
            line_mem[col1_reg] <= {cur1_reg, prev_reg[MW-1:VW]};
    end

    assign win_valid = v1_reg;
    assign win_flags = flags1_reg;
    assign cur_val   = signed'(cur1_reg);
    assign up_val    = signed'(prev_reg[VW-1:0]);
    assign mid_val   = signed'(prev_reg[MW-1:VW]);
    assign left_val  = signed'(left_reg);
    assign right_val = signed'(rd_reg[MW-1:VW]);

    // Read and write-back never touch the same entry in one cycle
    `JSS_NEVER(a_no_rw_clash, wr_en && accept && rd_ok && (col1_reg == rd_addr[AW-1:0]), "line memory read/write clash")
    // A row end wraps the column counter
    `JSS_ASSERT(a_row_wrap, (accept && row_end) |=> (col_reg == '0), "column counter did not wrap")
    // The frame-closing point carries no result
    `JSS_NEVER(a_end_no_emit, v1_reg && flags1_reg.frame_end && flags1_reg.emit, "frame end marked as emitting")

endmodule

`default_nettype wire

@@ rtl/jss_relax.sv @@
// ----------------------------------------------------------------------------
// jss_relax
// Update pipeline: four-neighbour average, SOR blend, saturation and the
// running L1 residual, ending in the result register. Every stage holds
// its own valid and stalls only when the stage ahead is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jss_relax
    import jss_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [WEIGHT_W-1:0]           relax_weight,
    // window from the line memory stage
    input  wire logic                          win_valid,
    output logic                               win_ready,
    input  wire item_flags_t                   win_flags,
    input  wire logic signed [VALUE_WIDTH-1:0] cur_val,
    input  wire logic signed [VALUE_WIDTH-1:0] up_val,
    input  wire logic signed [VALUE_WIDTH-1:0] left_val,
    input  wire logic signed [VALUE_WIDTH-1:0] mid_val,
    input  wire logic signed [VALUE_WIDTH-1:0] right_val,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [IO_VAL_W-1:0]                m_new_value,
    output logic [RES_W-1:0]                   m_residual,
    output logic                               m_tlast
);

    localparam int VW    = VALUE_WIDTH;
    localparam int SUM_W = VW + 3;
    localparam int AVG_W = VW + 1;
    localparam int DIF_W = VW + 2;
    localparam int MAG_W = VW + 1;
    localparam int PH_W  = MAG_W - 16 + WEIGHT_W;
    localparam int PL_W  = 16 + WEIGHT_W;
    localparam int Q_W   = PH_W + 1;
    localparam int SV_W  = VW + 4;
    localparam int CH_W  = VW + 1;

    localparam logic signed [SUM_W-1:0] AVG_RND = SUM_W'(2);
    localparam logic [PL_W:0]           Q_RND   = (PL_W+1)'(32768);
    localparam logic signed [SV_W-1:0]  SAT_HI  = {5'b00000, {(VW-1){1'b1}}};
    localparam logic signed [SV_W-1:0]  SAT_LO  = {5'b11111, {(VW-1){1'b0}}};

    function automatic logic signed [VW-1:0] sat_val(input logic signed [SV_W-1:0] x);
        logic signed [VW-1:0] y;
        priority if (x > SAT_HI)
            y = SAT_HI[VW-1:0];
        else if (x < SAT_LO)
            y = SAT_LO[VW-1:0];
        else
            y = x[VW-1:0];
        return y;
    endfunction

    // Handshake chain
    logic v2_reg, v3_reg, v4_reg, ov_reg;
    logic rdy2, rdy3, rdy4, out_free, adv4;

    assign out_free  = !ov_reg || m_tready;
    assign rdy4      = !v4_reg || out_free;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign adv4      = v4_reg && out_free;
    assign win_ready = rdy2;

    // Stage 2: average and difference
    item_flags_t              f2_reg;
    logic signed [AVG_W-1:0]  avg2_reg, avg_next;
    logic signed [VW-1:0]     mid2_reg;
    logic                     neg2_reg, neg_next;
    logic [MAG_W-1:0]         mag2_reg, mag_next;
    logic signed [SUM_W-1:0]  sum4;
    logic signed [DIF_W-1:0]  dif;
    logic [DIF_W-1:0]         dif_abs;

    always_comb begin
        sum4     = SUM_W'(up_val) + SUM_W'(left_val) + SUM_W'(right_val) + SUM_W'(cur_val);
        avg_next = AVG_W'((sum4 + AVG_RND) >>> 2);
        dif      = DIF_W'(avg_next) - DIF_W'(mid_val);
        neg_next = dif[DIF_W-1];
        dif_abs  = neg_next ? unsigned'(-dif) : unsigned'(dif);
        mag_next = dif_abs[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            f2_reg   <= win_flags;
            avg2_reg <= avg_next;
            mid2_reg <= mid_val;
            neg2_reg <= neg_next;
            mag2_reg <= mag_next;
        end
    end

    // Stage 3: weight products on the upper and lower 16-bit parts
    item_flags_t              f3_reg;
    logic signed [AVG_W-1:0]  avg3_reg;
    logic signed [VW-1:0]     mid3_reg;
    logic                     neg3_reg;
    logic [PH_W-1:0]          ph3_reg, ph_next;
    logic [PL_W-1:0]          pl3_reg, pl_next;

    assign ph_next = PH_W'(mag2_reg[MAG_W-1:16]) * PH_W'(relax_weight);
    assign pl_next = PL_W'(mag2_reg[15:0]) * PL_W'(relax_weight);

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            f3_reg   <= f2_reg;
            avg3_reg <= avg2_reg;
            mid3_reg <= mid2_reg;
            neg3_reg <= neg2_reg;
            ph3_reg  <= ph_next;
            pl3_reg  <= pl_next;
        end
    end

    // Stage 4: rounded step, blend, saturation and absolute change
    item_flags_t              f4_reg;
    logic signed [VW-1:0]     nv4_reg, nv_next;
    logic [CH_W-1:0]          ch4_reg, ch_next;
    logic [PL_W:0]            lo_rnd;
    logic [Q_W-1:0]           step_q;
    logic signed [SV_W-1:0]   mid_x, q_x, blend;
    logic signed [CH_W-1:0]   chg;

    always_comb begin
        lo_rnd  = (PL_W+1)'(pl3_reg) + Q_RND;
        step_q  = Q_W'(ph3_reg) + Q_W'(lo_rnd[PL_W:16]);
        mid_x   = SV_W'(mid3_reg);
        q_x     = signed'(SV_W'(step_q));
        blend   = neg3_reg ? (mid_x - q_x) : (mid_x + q_x);

        priority if (!f3_reg.sor)
            nv_next = sat_val(SV_W'(avg3_reg));
        else if (f3_reg.upd)
            nv_next = sat_val(blend);
        else
            nv_next = mid3_reg;

        chg     = CH_W'(nv_next) - CH_W'(mid3_reg);
        ch_next = chg[CH_W-1] ? unsigned'(-chg) : unsigned'(chg);
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            f4_reg  <= f3_reg;
            nv4_reg <= nv_next;
            ch4_reg <= ch_next;
        end
    end

    // Result register and saturating residual
    logic [RES_W-1:0]    acc_reg, acc_next;
    logic [RES_W:0]      acc_sum;
    logic [IO_VAL_W-1:0] nv_out_reg;
    logic [RES_W-1:0]    res_out_reg;
    logic                last_out_reg;

    always_comb begin
        acc_sum = {1'b0, acc_reg} + (RES_W+1)'(ch4_reg);
        priority if (f4_reg.frame_end)
            acc_next = '0;
        else if (!f4_reg.emit)
            acc_next = acc_reg;
        else if (acc_sum[RES_W])
            acc_next = '1;
        else
            acc_next = acc_sum[RES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            if (rdy2)
                v2_reg <= win_valid;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (out_free)
                ov_reg <= v4_reg && f4_reg.emit;
            if (adv4)
                acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4 && f4_reg.emit) begin
            nv_out_reg   <= IO_VAL_W'(unsigned'(nv4_reg));
            res_out_reg  <= acc_next;
            last_out_reg <= f4_reg.last;
        end
    end

    assign m_tvalid    = ov_reg;
    assign m_new_value = nv_out_reg;
    assign m_residual  = res_out_reg;
    assign m_tlast     = last_out_reg;

    // The residual only grows within a sweep
    `JSS_ASSERT(a_acc_grows, (adv4 && f4_reg.emit) |=> (acc_reg >= $past(acc_reg)), "residual went down")
    // The frame-closing point clears the residual
    `JSS_ASSERT(a_acc_clear, (adv4 && f4_reg.frame_end) |=> (acc_reg == '0), "residual not cleared")

endmodule

`default_nettype wire

@@ verif/jacobi_sor_stencil_sweep_test.sv @@
// ----------------------------------------------------------------------------
// jacobi_sor_stencil_sweep_test
// Self-checking bench for the five-point stencil sweep. Whole padded frames
// are streamed in raster order. A bit-exact stencil predictor holds its own
// line buffers, counters and residual. Every interior update is compared
// field by field with the result stream. Registers are programmed and read
// back over APB between frames. Frames run under several idle/stall mixes.
// ----------------------------------------------------------------------------
module jacobi_sor_stencil_sweep_test
    import jss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN      = MAX_COLS_DEF + 2;
    localparam int DRAIN_CYCLES  = 12;     // pipeline is 5 deep, allow margin
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;   // quiet cycles before giving up
    localparam int PHASE_POINTS  = 190;    // random points per idle phase

    localparam logic signed [63:0] VAL_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] VAL_MIN   = -64'sd2147483648;
    localparam logic        [63:0] RESID_MAX = 64'h00FF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] new_value;
        logic [55:0] residual;
        logic        last;
    } point_result_t;

    // 3x3 padded frame: every point rim_val except the single interior point
    typedef struct packed {
        cfg_t          cfg;
        logic [31:0]   rim_val;
        logic [31:0]   centre_val;
        logic          typed;
        point_result_t want;
    } directed_frame_t;

    // DUT signals
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;   // [31:0] grid_value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [87:0]        m_tdata;         // [31:0] new_value, [87:32] residual_sum
    logic               m_tlast;         // sweep_last
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Predictor state
    cfg_t               sweep_cfg;
    logic signed [63:0] line_mem [0:2*LINE_LEN-1];
    int unsigned        row_pos;
    int unsigned        col_pos;
    logic [63:0]        resid_acc;

    point_result_t      due_updates [$];

    // Run control and bookkeeping
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int fail_count      = 0;
    int points_sent     = 0;
    int results_checked = 0;
    int frames_sent     = 0;
    int configs_applied = 0;

    jacobi_sor_stencil_sweep u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic int unsigned effective_rows(cfg_t cf);
        if (cf.interior_rows == 0) return 1;
        if (cf.interior_rows > ROW_LIMIT) return ROW_LIMIT;
        return cf.interior_rows;
    endfunction

    function automatic int unsigned effective_cols(cfg_t cf);
        if (cf.interior_cols == 0) return 1;
        if (cf.interior_cols > MAX_COLS_DEF) return MAX_COLS_DEF;
        return cf.interior_cols;
    endfunction

    function automatic logic signed [63:0] clamp_value(logic signed [63:0] x);
        if (x > VAL_MAX) return VAL_MAX;
        if (x < VAL_MIN) return VAL_MIN;
        return x;
    endfunction

    // Stencil predictor: one padded point in, at most one interior update out
    task automatic stencil_update(input logic [31:0] gv, output bit emits,
                                  output point_result_t upd);
        int unsigned        rows, cols, r, c;
        logic signed [63:0] cur, up, left, mid, right, avg, d, nv;
        logic        [63:0] mag, w, q, ch;
        rows  = effective_rows(sweep_cfg);
        cols  = effective_cols(sweep_cfg);
        r     = row_pos;
        c     = col_pos;
        cur   = {{32{gv[31]}}, gv};
        emits = 1'b0;
        upd   = '0;
        if (r >= 2 && r <= rows + 1 && c >= 1 && c <= cols) begin
            up    = line_mem[(r % 2) * LINE_LEN + c];
            left  = line_mem[((r - 1) % 2) * LINE_LEN + c - 1];
            mid   = line_mem[((r - 1) % 2) * LINE_LEN + c];
            right = line_mem[((r - 1) % 2) * LINE_LEN + c + 1];
            // average rounded half up
            avg = (up + left + right + cur + 64'sd2) >>> 2;
            if (sweep_cfg.sweep_mode == MODE_JACOBI) begin
                nv = clamp_value(avg);
            end else if (((r - 1 + c) % 2) == sweep_cfg.colour_select) begin
                // w*(avg-u) on the magnitude, rounded to nearest, ties away
                d   = avg - mid;
                mag = (d < 0) ? -d : d;
                w   = 64'(sweep_cfg.relax_weight);
                q   = (mag >> 16) * w + (((mag & 64'hFFFF) * w + 64'h8000) >> 16);
                nv  = clamp_value((d < 0) ? mid - signed'(q) : mid + signed'(q));
            end else begin
                nv = mid;
            end
            ch = (nv < mid) ? mid - nv : nv - mid;
            resid_acc = (ch > RESID_MAX - resid_acc) ? RESID_MAX : resid_acc + ch;
            upd.new_value = nv[31:0];
            upd.residual  = resid_acc[55:0];
            upd.last      = (r == rows + 1 && c == cols);
            emits = 1'b1;
        end
        if (c < LINE_LEN) line_mem[(r % 2) * LINE_LEN + c] = cur;
        // raster counters; frame end clears the residual
        if (c >= cols + 1) begin
            col_pos = 0;
            if (r >= rows + 1) begin
                row_pos   = 0;
                resid_acc = '0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    // One input transaction, with random sender gaps in front of it
    task automatic stream_point(input logic [31:0] gv, input bit typed,
                                input point_result_t typed_upd);
        bit            emits;
        point_result_t upd;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= gv;
        do @(posedge aclk); while (!s_tready);
        stencil_update(gv, emits, upd);
        if (emits) due_updates.push_back(typed ? typed_upd : upd);
        points_sent++;
    endtask

    // Stop sending and let every pending update and the frame-end clear finish
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (due_updates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB transaction; psel/penable stay up so transactions can chain
    task automatic apb_access(input bit wr, input reg_idx_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    // Write all five registers, read them back, then adopt the new settings
    task automatic program_config(input cfg_t cf);
        reg_idx_t    regs [5];
        logic [31:0] vals [5];
        logic [31:0] rd;
        regs = '{REG_ROWS, REG_COLS, REG_MODE, REG_WEIGHT, REG_COLOUR};
        vals = '{32'(cf.interior_rows), 32'(cf.interior_cols), 32'(cf.sweep_mode),
                 32'(cf.relax_weight), 32'(cf.colour_select)};
        for (int i = 0; i < 5; i++) apb_access(1'b1, regs[i], vals[i], rd);
        for (int i = 0; i < 5; i++) begin
            apb_access(1'b0, regs[i], '0, rd);
            if (rd !== vals[i])
                flag_error($sformatf("readback %s: expected %h, got %h",
                                     regs[i].name(), vals[i], rd));
        end
        psel      <= 1'b0;
        penable   <= 1'b0;
        sweep_cfg = cf;
        configs_applied++;
    endtask

    function automatic logic [31:0] random_grid_value();
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            // moderate Q16.16 values, about +/-32
            default: return 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
        endcase
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t cf;
        cf.interior_rows = ($urandom_range(0, 9) == 0) ? '0 : ROWS_W'($urandom_range(1, 6));
        cf.interior_cols = ($urandom_range(0, 9) == 0) ? '0 : COLS_W'($urandom_range(1, 9));
        cf.sweep_mode    = ($urandom_range(0, 2) == 0) ? MODE_JACOBI : MODE_SOR;
        case ($urandom_range(0, 3))
            0:       cf.relax_weight = '0;
            1:       cf.relax_weight = '1;
            2:       cf.relax_weight = WEIGHT_RST;
            default: cf.relax_weight = WEIGHT_W'($urandom());
        endcase
        cf.colour_select = 1'($urandom_range(0, 1));
        return cf;
    endfunction

    task automatic stream_random_frame();
        int unsigned n;
        n = (effective_rows(sweep_cfg) + 2) * (effective_cols(sweep_cfg) + 2);
        repeat (n) stream_point(random_grid_value(), 1'b0, '0);
        frames_sent++;
    endtask

    // Receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin : check_results
        point_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_updates.size() == 0) begin
                flag_error($sformatf("unexpected result transaction, tdata %h", m_tdata));
            end else begin
                want = due_updates.pop_front();
                results_checked++;
                if (m_tdata[31:0] !== want.new_value)
                    flag_error($sformatf("new_value: expected %h, got %h",
                                         want.new_value, m_tdata[31:0]));
                if (m_tdata[87:32] !== want.residual)
                    flag_error($sformatf("residual_sum: expected %h, got %h",
                                         want.residual, m_tdata[87:32]));
                if (m_tlast !== want.last)
                    flag_error($sformatf("sweep_last: expected %b, got %b",
                                         want.last, m_tlast));
            end
        end
    end

    // Watchdog on quiet cycles
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("** jacobi_sor_stencil_sweep: FAILED **");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        directed_frame_t dir_table [3];
        int              phase_start;
        int              idle_mix [4][2];

        idle_mix = '{'{0, 0}, '{55, 0}, '{0, 55}, '{9, 9}};

        // zero sizes act as one; maximum neighbours over a minimum centre
        dir_table[0] = '{cfg: '{interior_rows: '0, interior_cols: '0,
                                sweep_mode: MODE_JACOBI, relax_weight: WEIGHT_RST,
                                colour_select: 1'b0},
                         rim_val: 32'h7FFF_FFFF, centre_val: 32'h8000_0000, typed: 1'b1,
                         want: '{new_value: 32'h7FFF_FFFF, residual: 56'hFFFF_FFFF,
                                 last: 1'b1}};
        // SOR at the largest weight saturates low; residual restarts after frame end
        dir_table[1] = '{cfg: '{interior_rows: ROWS_W'(1), interior_cols: COLS_W'(1),
                                sweep_mode: MODE_SOR, relax_weight: '1,
                                colour_select: 1'b0},
                         rim_val: 32'h8000_0000, centre_val: 32'h7FFF_FFFF, typed: 1'b1,
                         want: '{new_value: 32'h8000_0000, residual: 56'hFFFF_FFFF,
                                 last: 1'b1}};
        // SOR on the other colour passes the point through unchanged
        dir_table[2] = '{cfg: '{interior_rows: ROWS_W'(1), interior_cols: COLS_W'(1),
                                sweep_mode: MODE_SOR, relax_weight: WEIGHT_RST,
                                colour_select: 1'b1},
                         rim_val: 32'h0001_0000, centre_val: 32'h1234_5678, typed: 1'b1,
                         want: '{new_value: 32'h1234_5678, residual: '0, last: 1'b1}};

        sweep_cfg = '{interior_rows: ROWS_RST, interior_cols: COLS_RST,
                      sweep_mode: MODE_JACOBI, relax_weight: WEIGHT_RST,
                      colour_select: 1'b0};
        row_pos   = 0;
        col_pos   = 0;
        resid_acc = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames
        for (int f = 0; f < 3; f++) begin
            wait_drain();
            program_config(dir_table[f].cfg);
            for (int k = 0; k < 9; k++)
                stream_point((k == 4) ? dir_table[f].centre_val : dir_table[f].rim_val,
                             dir_table[f].typed, dir_table[f].want);
            frames_sent++;
        end

        // Random small frames under each idle mix
        for (int p = 0; p < 4; p++) begin
            wait_drain();
            sender_idle_pct = idle_mix[p][0];
            recv_stall_pct  = idle_mix[p][1];
            program_config(random_cfg());
            phase_start = points_sent;
            if (p == 0) hold_requests <= hold_requests + 1;
            while (points_sent - phase_start < PHASE_POINTS) begin
                // either reprogram between frames or run straight into the next one
                if ($urandom_range(0, 1) == 0) begin
                    wait_drain();
                    program_config(random_cfg());
                end
                stream_random_frame();
            end
        end

        wait_drain();
        if (due_updates.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", due_updates.size()));

        $display("Run: %0d grid points in %0d frames over %0d register settings",
                 points_sent, frames_sent, configs_applied);
        $display("Jacobi and SOR on both colours, zero and small sizes, long output hold;%s",
                 $sformatf(" %0d interior updates checked, %0d errors",
                           results_checked, fail_count));
        if (fail_count == 0) begin
            $display("** jacobi_sor_stencil_sweep: PASSED **");
        end else begin
            $display("** jacobi_sor_stencil_sweep: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/jss_pkg.sv
rtl/jss_cfg_regs.sv
rtl/jss_window.sv
rtl/jss_relax.sv
rtl/jacobi_sor_stencil_sweep.sv
verif/jacobi_sor_stencil_sweep_test.sv
